// ----- rtl/bir_pkg.sv -----
// ----------------------------------------------------------------------------
// Bilinear image resize package
// Shared constants, register map and controller state type for the scaler.
// ----------------------------------------------------------------------------
package bir_pkg;

  // Default sizing of the frame store and of the fixed-point step.
  localparam int MAX_SRC_WIDTH_DEFAULT  = 512;
  localparam int MAX_SRC_HEIGHT_DEFAULT = 512;
  localparam int FRACTION_BITS_DEFAULT  = 10;

  // Largest destination size that a request may address.
  localparam int MAX_DST_SIZE = 2048;

  // Field widths of the transactions.
  localparam int SRC_COORD_W = 9;
  localparam int DST_COORD_W = 11;
  localparam int PIXEL_W     = 8;

  // Configuration register widths.
  localparam int SRC_SIZE_W = 10;
  localparam int DST_SIZE_W = 12;
  localparam int RATIO_W    = 20;

  // Configuration port.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Register reset values.
  localparam logic [SRC_SIZE_W-1:0] SRC_WIDTH_RESET  = SRC_SIZE_W'(320);
  localparam logic [SRC_SIZE_W-1:0] SRC_HEIGHT_RESET = SRC_SIZE_W'(240);
  localparam logic [DST_SIZE_W-1:0] DST_WIDTH_RESET  = DST_SIZE_W'(512);
  localparam logic [DST_SIZE_W-1:0] DST_HEIGHT_RESET = DST_SIZE_W'(512);
  localparam logic [RATIO_W-1:0]    RATIO_X_RESET    = RATIO_W'(640);
  localparam logic [RATIO_W-1:0]    RATIO_Y_RESET    = RATIO_W'(480);

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [2:0] REG_RATIO_X    = 3'd4;
  localparam logic [2:0] REG_RATIO_Y    = 3'd5;

  // Input transaction kinds.
  localparam logic KIND_STORE   = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  // Request sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_SETUP,
    ST_READ,
    ST_DRAIN,
    ST_FINISH
  } bir_state_t;

endpackage

// ----- rtl/bilinear_image_resize.sv -----
// ----------------------------------------------------------------------------
// Bilinear image resize
// Stores an 8-bit source image and answers destination pixel requests with a
// bilinear interpolation of the four neighboring source pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction per item.
//   A store transaction (kind 0) writes pixel_in at (src_col, src_row) into
//   the frame store when inside the source size; it gives no result. A request
//   transaction (kind 1) gives exactly one result on the output channel
//   (out_valid / out_stall) with pixel_out and out_of_range.
//   A request inside the destination passes through a mapping step, a setup
//   step, four tap reads, a drain step and a final step that loads the output
//   register; on the last source row or column only the nearest pixel is read.
//   An out-of-range request goes from the mapping step to the final step. The
//   single port of the frame store serves one tap per cycle. Stores are taken
//   one per cycle; while a request is under way no new item is taken.
//   The output register holds a finished result while the receiver stalls,
//   and the next item is accepted meanwhile; a later request waits in its
//   last step until the output register is free.
//   Reset loads the register defaults and empties the output register. The
//   frame store is not cleared: a pixel must be stored before it is used. The
//   user must do configuration via the APB port while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module bilinear_image_resize #(
  parameter int MAX_SRC_WIDTH  = bir_pkg::MAX_SRC_WIDTH_DEFAULT,
  parameter int MAX_SRC_HEIGHT = bir_pkg::MAX_SRC_HEIGHT_DEFAULT,
  parameter int FRACTION_BITS  = bir_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bir_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [bir_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [bir_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic [bir_pkg::SRC_COORD_W-1:0]   src_col,
  input  logic [bir_pkg::SRC_COORD_W-1:0]   src_row,
  input  logic [bir_pkg::PIXEL_W-1:0]       pixel_in,
  input  logic [bir_pkg::DST_COORD_W-1:0]   dst_col,
  input  logic [bir_pkg::DST_COORD_W-1:0]   dst_row,
  // Output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bir_pkg::PIXEL_W-1:0]       pixel_out,
  output logic                              out_of_range
);

  localparam int DEPTH   = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(MAX_SRC_WIDTH);
  localparam int RW      = $clog2(MAX_SRC_HEIGHT);
  localparam int SW_W    = $clog2(MAX_SRC_WIDTH + 1);
  localparam int SH_W    = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int PX_W    = bir_pkg::DST_COORD_W + bir_pkg::RATIO_W;
  localparam int IX_W    = PX_W - FRACTION_BITS;
  localparam int FQ_W    = FRACTION_BITS + 1;
  localparam int WGT_W   = 2 * FRACTION_BITS + 1;
  localparam int WGTP_W  = 2 * FQ_W;
  localparam int ACC_W   = 2 * FRACTION_BITS + bir_pkg::PIXEL_W;

  // Configuration registers
  logic [bir_pkg::SRC_SIZE_W-1:0] src_width;
  logic [bir_pkg::SRC_SIZE_W-1:0] src_height;
  logic [bir_pkg::DST_SIZE_W-1:0] dst_width;
  logic [bir_pkg::DST_SIZE_W-1:0] dst_height;
  logic [bir_pkg::RATIO_W-1:0]    ratio_x;
  logic [bir_pkg::RATIO_W-1:0]    ratio_y;
  logic                           cfg_write;

  // Sequencer state and request registers
  bir_pkg::bir_state_t state;
  bir_pkg::bir_state_t state_next;
  logic [bir_pkg::DST_COORD_W-1:0] dc_q;
  logic [bir_pkg::DST_COORD_W-1:0] dr_q;
  logic                            oor;
  logic [IX_W-1:0]                 ix;
  logic [IX_W-1:0]                 iy;
  logic [FRACTION_BITS-1:0]        fx;
  logic [FRACTION_BITS-1:0]        fy;
  logic                            near;
  logic [CW-1:0]                   xc;
  logic [RW-1:0]                   yc;
  logic [1:0]                      tap_cnt;
  logic [1:0]                      tap_last;
  logic [WGT_W-1:0]                w_q;
  logic                            rd_pend;
  logic [ACC_W-1:0]                acc;

  // Combinational helpers
  logic [SW_W-1:0]          sw_eff;
  logic [SH_W-1:0]          sh_eff;
  logic [CW-1:0]            sw_last;
  logic [RW-1:0]            sh_last;
  logic                     in_accept;
  logic                     store_ok;
  logic                     oor_c;
  logic [PX_W-1:0]          px_x;
  logic [PX_W-1:0]          px_y;
  logic                     near_c;
  logic [CW-1:0]            xc_c;
  logic [RW-1:0]            yc_c;
  logic [CW-1:0]            tap_col;
  logic [RW-1:0]            tap_row;
  logic [FQ_W-1:0]          one_q;
  logic [FQ_W-1:0]          wa;
  logic [FQ_W-1:0]          wb;
  logic [WGTP_W-1:0]        w_prod;
  logic [ACC_W-1:0]         mac;
  logic                     out_free;

  // Frame store port
  logic                       ram_we;
  logic [AW-1:0]              ram_addr;
  logic [bir_pkg::PIXEL_W-1:0] ram_rdata;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Register writes land on the access cycle of an APB write.
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= bir_pkg::SRC_WIDTH_RESET;
      src_height <= bir_pkg::SRC_HEIGHT_RESET;
      dst_width  <= bir_pkg::DST_WIDTH_RESET;
      dst_height <= bir_pkg::DST_HEIGHT_RESET;
      ratio_x    <= bir_pkg::RATIO_X_RESET;
      ratio_y    <= bir_pkg::RATIO_Y_RESET;
    end else if (cfg_write) begin
      case (paddr[4:2])
        bir_pkg::REG_SRC_WIDTH:  src_width  <= pwdata[bir_pkg::SRC_SIZE_W-1:0];
        bir_pkg::REG_SRC_HEIGHT: src_height <= pwdata[bir_pkg::SRC_SIZE_W-1:0];
        bir_pkg::REG_DST_WIDTH:  dst_width  <= pwdata[bir_pkg::DST_SIZE_W-1:0];
        bir_pkg::REG_DST_HEIGHT: dst_height <= pwdata[bir_pkg::DST_SIZE_W-1:0];
        bir_pkg::REG_RATIO_X:    ratio_x    <= pwdata[bir_pkg::RATIO_W-1:0];
        bir_pkg::REG_RATIO_Y:    ratio_y    <= pwdata[bir_pkg::RATIO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read data follows the address.
  always_comb begin
    case (paddr[4:2])
      bir_pkg::REG_SRC_WIDTH:  prdata = bir_pkg::CFG_DATA_W'(src_width);
      bir_pkg::REG_SRC_HEIGHT: prdata = bir_pkg::CFG_DATA_W'(src_height);
      bir_pkg::REG_DST_WIDTH:  prdata = bir_pkg::CFG_DATA_W'(dst_width);
      bir_pkg::REG_DST_HEIGHT: prdata = bir_pkg::CFG_DATA_W'(dst_height);
      bir_pkg::REG_RATIO_X:    prdata = bir_pkg::CFG_DATA_W'(ratio_x);
      bir_pkg::REG_RATIO_Y:    prdata = bir_pkg::CFG_DATA_W'(ratio_y);
      default:                 prdata = '0;
    endcase
  end

  // Effective source size, saturated to the frame store, and its last index.
  always_comb begin
    if (src_width == '0) begin
      sw_eff = SW_W'(1);
    end else if (32'(src_width) > MAX_SRC_WIDTH) begin
      sw_eff = SW_W'(MAX_SRC_WIDTH);
    end else begin
      sw_eff = SW_W'(src_width);
    end
    if (src_height == '0) begin
      sh_eff = SH_W'(1);
    end else if (32'(src_height) > MAX_SRC_HEIGHT) begin
      sh_eff = SH_W'(MAX_SRC_HEIGHT);
    end else begin
      sh_eff = SH_W'(src_height);
    end
    sw_last = CW'(sw_eff - SW_W'(1));
    sh_last = RW'(sh_eff - SH_W'(1));
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  assign in_accept = in_valid && !in_stall;

  // A store inside the source image writes the frame store at acceptance.
  assign store_ok = (32'(src_col) < 32'(sw_eff)) && (32'(src_row) < 32'(sh_eff));

  // Request coordinates are kept for the mapping step.
  always_ff @(posedge clk) begin
    if (in_accept && kind == bir_pkg::KIND_REQUEST) begin
      dc_q <= dst_col;
      dr_q <= dst_row;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------

  assign out_free = !out_valid || !out_stall;
  assign tap_last = near ? 2'd0 : 2'd3;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      bir_pkg::ST_IDLE: begin
        if (in_valid && kind == bir_pkg::KIND_REQUEST) begin
          state_next = bir_pkg::ST_MAP;
        end
      end
      bir_pkg::ST_MAP: begin
        state_next = oor_c ? bir_pkg::ST_FINISH : bir_pkg::ST_SETUP;
      end
      bir_pkg::ST_SETUP: begin
        state_next = bir_pkg::ST_READ;
      end
      bir_pkg::ST_READ: begin
        if (tap_cnt == tap_last) begin
          state_next = bir_pkg::ST_DRAIN;
        end
      end
      bir_pkg::ST_DRAIN: begin
        state_next = bir_pkg::ST_FINISH;
      end
      bir_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = bir_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bir_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: input stall and frame store port.
  always_comb begin
    in_stall = 1'b1;
    ram_we   = 1'b0;
    ram_addr = AW'(32'(tap_row) * MAX_SRC_WIDTH) + AW'(tap_col);
    case (state)
      bir_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        ram_we   = in_valid && kind == bir_pkg::KIND_STORE && store_ok;
        ram_addr = AW'(32'(RW'(src_row)) * MAX_SRC_WIDTH) + AW'(CW'(src_col));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bir_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Coordinate mapping
  // --------------------------------------------------------------------------

  // Destination bounds and fixed-point source position.
  always_comb begin
    oor_c = (32'(dc_q) >= 32'(dst_width)) || (32'(dc_q) >= bir_pkg::MAX_DST_SIZE) ||
            (32'(dr_q) >= 32'(dst_height)) || (32'(dr_q) >= bir_pkg::MAX_DST_SIZE);
    px_x  = PX_W'(dc_q) * PX_W'(ratio_x);
    px_y  = PX_W'(dr_q) * PX_W'(ratio_y);
  end

  // Nearest-pixel decision and saturated tap origin.
  always_comb begin
    near_c = (32'(ix) >= 32'(sw_last)) || (32'(iy) >= 32'(sh_last));
    xc_c   = (32'(ix) > 32'(sw_last)) ? sw_last : CW'(ix);
    yc_c   = (32'(iy) > 32'(sh_last)) ? sh_last : RW'(iy);
  end

  always_ff @(posedge clk) begin
    if (state == bir_pkg::ST_MAP) begin
      oor <= oor_c;
      ix  <= px_x[PX_W-1:FRACTION_BITS];
      iy  <= px_y[PX_W-1:FRACTION_BITS];
      fx  <= px_x[FRACTION_BITS-1:0];
      fy  <= px_y[FRACTION_BITS-1:0];
    end else if (state == bir_pkg::ST_SETUP) begin
      // The nearest pixel is one tap with full weight.
      xc   <= xc_c;
      yc   <= yc_c;
      near <= near_c;
      if (near_c) begin
        fx <= '0;
        fy <= '0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tap reads and accumulation
  // --------------------------------------------------------------------------

  // Tap position and weight; bit 0 of the tap steps right, bit 1 steps down.
  always_comb begin
    one_q   = FQ_W'(1) << FRACTION_BITS;
    tap_col = xc + CW'(tap_cnt[0]);
    tap_row = yc + RW'(tap_cnt[1]);
    wa      = tap_cnt[0] ? {1'b0, fx} : one_q - {1'b0, fx};
    wb      = tap_cnt[1] ? {1'b0, fy} : one_q - {1'b0, fy};
    w_prod  = WGTP_W'(wa) * WGTP_W'(wb);
    mac     = ACC_W'(w_q) * ACC_W'(ram_rdata);
  end

  // Tap counter and read-pending flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_cnt <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= (state == bir_pkg::ST_READ);
      if (state == bir_pkg::ST_READ) begin
        tap_cnt <= tap_cnt + 2'd1;
      end else begin
        tap_cnt <= '0;
      end
    end
  end

  // The weight travels with its read; the product is added in the cycle after.
  always_ff @(posedge clk) begin
    if (state == bir_pkg::ST_READ) begin
      w_q <= w_prod[WGT_W-1:0];
    end
    if (state == bir_pkg::ST_MAP) begin
      acc <= '0;
    end else if (rd_pend) begin
      acc <= acc + mac;
    end
  end

  bir_ram #(
    .WIDTH (bir_pkg::PIXEL_W),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (pixel_in),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == bir_pkg::ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bir_pkg::ST_FINISH && out_free) begin
      pixel_out    <= oor ? '0 : acc[2*FRACTION_BITS +: bir_pkg::PIXEL_W];
      out_of_range <= oor;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // The frame store is written only by stores taken while idle.
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == bir_pkg::ST_IDLE && in_accept))
    else $error("frame store written outside an accepted store");

  // A new result appears only from the final step of a request.
  a_load_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == bir_pkg::ST_FINISH)
    else $error("output loaded outside the final step");

  // The last tap's data is always pending when draining.
  a_drain_pend: assert property (@(posedge clk) disable iff (rst)
    state == bir_pkg::ST_DRAIN |-> rd_pend)
    else $error("drain without a pending read");

  // The nearest pixel takes a single tap.
  a_near_one_tap: assert property (@(posedge clk) disable iff (rst)
    (state == bir_pkg::ST_READ && near) |-> tap_cnt == 2'd0)
    else $error("nearest-pixel request issued more than one tap");

  // An out-of-range result carries a zero pixel.
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_of_range) |-> pixel_out == '0)
    else $error("out-of-range result with a nonzero pixel");

endmodule

// ----- rtl/bir_ram.sv -----
// ----------------------------------------------------------------------------
// Bilinear image resize RAM
// Generic single-port synchronous RAM with one write and a registered read.
// ----------------------------------------------------------------------------
module bir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port share one address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- test/bilinear_image_resize_test.sv -----
// ----------------------------------------------------------------------------
// Bilinear image resize testbench
// Drives store and request transactions into the scaler with random gaps and
// output stalls. A scoreboard holds its own copy of the frame store and the
// registers, predicts each destination pixel and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bilinear_image_resize_test;

  localparam int FRAC_W        = bir_pkg::FRACTION_BITS_DEFAULT;
  localparam int ONE_Q         = 1 << FRAC_W;
  localparam int SRC_W_MAX     = bir_pkg::MAX_SRC_WIDTH_DEFAULT;
  localparam int SRC_H_MAX     = bir_pkg::MAX_SRC_HEIGHT_DEFAULT;
  localparam int STORE_DEPTH   = SRC_W_MAX * SRC_H_MAX;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int HOLD_CYCLES   = 300;
  localparam int RATIO_MAX     = (1 << bir_pkg::RATIO_W) - 1;

  // Register indexes with no register behind them.
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [bir_pkg::PIXEL_W-1:0] pixel;
    logic                        flag;
  } scaled_pixel_t;

  // Ports of the block.
  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [bir_pkg::CFG_ADDR_W-1:0]  paddr = '0;
  logic [bir_pkg::CFG_DATA_W-1:0]  pwdata = '0;
  logic [bir_pkg::CFG_DATA_W-1:0]  prdata;
  logic                            pready;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            kind = bir_pkg::KIND_STORE;
  logic [bir_pkg::SRC_COORD_W-1:0] src_col = '0;
  logic [bir_pkg::SRC_COORD_W-1:0] src_row = '0;
  logic [bir_pkg::PIXEL_W-1:0]     pixel_in = '0;
  logic [bir_pkg::DST_COORD_W-1:0] dst_col = '0;
  logic [bir_pkg::DST_COORD_W-1:0] dst_row = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [bir_pkg::PIXEL_W-1:0]     pixel_out;
  logic                            out_of_range;

  // Scoreboard copy of the registers and the frame store.
  logic [bir_pkg::SRC_SIZE_W-1:0] cfg_src_width  = bir_pkg::SRC_WIDTH_RESET;
  logic [bir_pkg::SRC_SIZE_W-1:0] cfg_src_height = bir_pkg::SRC_HEIGHT_RESET;
  logic [bir_pkg::DST_SIZE_W-1:0] cfg_dst_width  = bir_pkg::DST_WIDTH_RESET;
  logic [bir_pkg::DST_SIZE_W-1:0] cfg_dst_height = bir_pkg::DST_HEIGHT_RESET;
  logic [bir_pkg::RATIO_W-1:0]    cfg_ratio_x    = bir_pkg::RATIO_X_RESET;
  logic [bir_pkg::RATIO_W-1:0]    cfg_ratio_y    = bir_pkg::RATIO_Y_RESET;
  logic [bir_pkg::PIXEL_W-1:0]    frame_copy [STORE_DEPTH];
  bit                             pixel_written [STORE_DEPTH];

  scaled_pixel_t pending_pixels [$];
  int            mismatches = 0;
  int            cycle_count = 0;
  bit            no_idle = 1'b0;
  int            hold_request = 0;
  int            stall_left = 0;
  int            hold_left = 0;

  bilinear_image_resize uut (.*);

  always #5 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[bilinear_image_resize] ERROR");
      $finish;
    end
  end

  function automatic int saturate(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int eff_src_width();
    return saturate(cfg_src_width, 1, SRC_W_MAX);
  endfunction

  function automatic int eff_src_height();
    return saturate(cfg_src_height, 1, SRC_H_MAX);
  endfunction

  function automatic int eff_dst_width();
    return saturate(cfg_dst_width, 0, bir_pkg::MAX_DST_SIZE);
  endfunction

  function automatic int eff_dst_height();
    return saturate(cfg_dst_height, 0, bir_pkg::MAX_DST_SIZE);
  endfunction

  // Maps a destination coordinate to a source index and fraction.
  function automatic void map_request(input int dc, input int dr, output bit outside,
                                      output bit nearest, output int xc, output int yc,
                                      output int fx, output int fy);
    int sw;
    int sh;
    longint unsigned px;
    longint unsigned py;
    longint unsigned ix;
    longint unsigned iy;
    sw = eff_src_width();
    sh = eff_src_height();
    outside = (dc >= eff_dst_width()) || (dr >= eff_dst_height());
    nearest = 1'b0;
    xc = 0;
    yc = 0;
    fx = 0;
    fy = 0;
    if (outside) return;
    px = 64'(dc) * 64'(cfg_ratio_x);
    py = 64'(dr) * 64'(cfg_ratio_y);
    ix = px >> FRAC_W;
    iy = py >> FRAC_W;
    fx = int'(px & 64'(ONE_Q - 1));
    fy = int'(py & 64'(ONE_Q - 1));
    // On the last row or column the nearest pixel is used.
    if (ix >= 64'(sw - 1) || iy >= 64'(sh - 1)) begin
      nearest = 1'b1;
      xc = (ix > 64'(sw - 1)) ? sw - 1 : int'(ix);
      yc = (iy > 64'(sh - 1)) ? sh - 1 : int'(iy);
    end else begin
      xc = int'(ix);
      yc = int'(iy);
    end
  endfunction

  function automatic longint unsigned stored_pixel(input int col, input int row);
    return 64'(frame_copy[row * SRC_W_MAX + col]);
  endfunction

  // Expected result of one request transaction.
  function automatic scaled_pixel_t resize_predict(input int dc, input int dr);
    bit outside;
    bit nearest;
    int xc;
    int yc;
    int fx;
    int fy;
    longint unsigned acc;
    scaled_pixel_t res;
    map_request(dc, dr, outside, nearest, xc, yc, fx, fy);
    res.flag  = outside;
    res.pixel = '0;
    if (outside) return res;
    if (nearest) begin
      res.pixel = bir_pkg::PIXEL_W'(stored_pixel(xc, yc));
    end else begin
      acc = 64'(ONE_Q - fx) * 64'(ONE_Q - fy) * stored_pixel(xc, yc)
          + 64'(fx) * 64'(ONE_Q - fy) * stored_pixel(xc + 1, yc)
          + 64'(ONE_Q - fx) * 64'(fy) * stored_pixel(xc, yc + 1)
          + 64'(fx) * 64'(fy) * stored_pixel(xc + 1, yc + 1);
      res.pixel = bir_pkg::PIXEL_W'(acc >> (2 * FRAC_W));
    end
    return res;
  endfunction

  // A store outside the effective source size leaves the frame untouched.
  function automatic void record_store(input int col, input int row, input int value);
    if (col < eff_src_width() && row < eff_src_height()) begin
      frame_copy[row * SRC_W_MAX + col]    = bir_pkg::PIXEL_W'(value);
      pixel_written[row * SRC_W_MAX + col] = 1'b1;
    end
  endfunction

  function automatic void apply_register(input logic [2:0] index,
                                         input logic [bir_pkg::CFG_DATA_W-1:0] value);
    case (index)
      bir_pkg::REG_SRC_WIDTH: begin
        cfg_src_width = value[bir_pkg::SRC_SIZE_W-1:0];
      end
      bir_pkg::REG_SRC_HEIGHT: begin
        cfg_src_height = value[bir_pkg::SRC_SIZE_W-1:0];
      end
      bir_pkg::REG_DST_WIDTH: begin
        cfg_dst_width = value[bir_pkg::DST_SIZE_W-1:0];
      end
      bir_pkg::REG_DST_HEIGHT: begin
        cfg_dst_height = value[bir_pkg::DST_SIZE_W-1:0];
      end
      bir_pkg::REG_RATIO_X: begin
        cfg_ratio_x = value[bir_pkg::RATIO_W-1:0];
      end
      bir_pkg::REG_RATIO_Y: begin
        cfg_ratio_y = value[bir_pkg::RATIO_W-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  // Sender gap: mostly none or short, now and then long.
  function automatic int idle_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int stall_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Random bits above the register width must not matter.
  function automatic logic [bir_pkg::CFG_DATA_W-1:0] with_junk(input int value,
                                                               input int width);
    logic [bir_pkg::CFG_DATA_W-1:0] mask;
    mask = (bir_pkg::CFG_DATA_W'(1) << width) - 1;
    return ($urandom & ~mask) | (bir_pkg::CFG_DATA_W'(value) & mask);
  endfunction

  // Offers one input transaction and updates the scoreboard once it is taken.
  task automatic send_item(input logic k, input int sc, input int sr, input int pv,
                           input int dc, input int dr);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    src_col  <= bir_pkg::SRC_COORD_W'(sc);
    src_row  <= bir_pkg::SRC_COORD_W'(sr);
    pixel_in <= bir_pkg::PIXEL_W'(pv);
    dst_col  <= bir_pkg::DST_COORD_W'(dc);
    dst_row  <= bir_pkg::DST_COORD_W'(dr);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (k == bir_pkg::KIND_STORE) begin
      record_store(sc, sr, pv);
    end else begin
      pending_pixels.push_back(resize_predict(dc, dr));
    end
  endtask

  task automatic send_store(input int col, input int row, input int value);
    send_item(bir_pkg::KIND_STORE, col, row, value, $urandom_range(0, 2047),
              $urandom_range(0, 2047));
  endtask

  // Stores any source pixel that the request would read before it was written.
  task automatic request_pixel(input int dc, input int dr);
    bit outside;
    bit nearest;
    int xc;
    int yc;
    int fx;
    int fy;
    map_request(dc, dr, outside, nearest, xc, yc, fx, fy);
    if (!outside) begin
      for (int i = 0; i < (nearest ? 1 : 4); i++) begin
        if (!pixel_written[(yc + i / 2) * SRC_W_MAX + xc + i % 2]) begin
          send_store(xc + i % 2, yc + i / 2, $urandom_range(0, 255));
        end
      end
    end
    send_item(bir_pkg::KIND_REQUEST, $urandom_range(0, 511), $urandom_range(0, 511),
              $urandom_range(0, 255), dc, dr);
  endtask

  task automatic cfg_write(input logic [2:0] index,
                           input logic [bir_pkg::CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    apply_register(index, value);
    @(posedge clk);
  endtask

  // Waits until every result is in and the block has settled.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_scaling(input int sw, input int sh, input int dw, input int dh,
                             input int rx, input int ry);
    wait_for_idle();
    cfg_write(bir_pkg::REG_SRC_WIDTH, with_junk(sw, bir_pkg::SRC_SIZE_W));
    cfg_write(bir_pkg::REG_SRC_HEIGHT, with_junk(sh, bir_pkg::SRC_SIZE_W));
    cfg_write(bir_pkg::REG_DST_WIDTH, with_junk(dw, bir_pkg::DST_SIZE_W));
    cfg_write(bir_pkg::REG_DST_HEIGHT, with_junk(dh, bir_pkg::DST_SIZE_W));
    cfg_write(bir_pkg::REG_RATIO_X, with_junk(rx, bir_pkg::RATIO_W));
    cfg_write(bir_pkg::REG_RATIO_Y, with_junk(ry, bir_pkg::RATIO_W));
  endtask

  function automatic int pick_src_size();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(2, 24);
    if (r < 8) return $urandom_range(25, SRC_W_MAX);
    return $urandom_range(0, (1 << bir_pkg::SRC_SIZE_W) - 1);
  endfunction

  function automatic int pick_dst_size();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(1, 48);
    if (r < 8) return $urandom_range(49, bir_pkg::MAX_DST_SIZE);
    return $urandom_range(0, (1 << bir_pkg::DST_SIZE_W) - 1);
  endfunction

  // Ratio as software writes it, or now and then any value.
  function automatic int ratio_for(input int src, input int dst);
    int s;
    int d;
    s = saturate(src, 1, SRC_W_MAX);
    d = saturate(dst, 0, bir_pkg::MAX_DST_SIZE);
    if (d == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, RATIO_MAX);
    return (ONE_Q * s) / d;
  endfunction

  // Mostly requests inside the destination, with stores and noise mixed in.
  task automatic random_traffic(input int count);
    int r;
    int dw;
    int dh;
    for (int n = 0; n < count; n++) begin
      r  = $urandom_range(0, 99);
      dw = eff_dst_width();
      dh = eff_dst_height();
      if (r < 12) begin
        send_store($urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 255));
      end else if (r < 22) begin
        send_store($urandom_range(0, eff_src_width() - 1),
                   $urandom_range(0, eff_src_height() - 1), $urandom_range(0, 255));
      end else if (r < 32 || dw == 0 || dh == 0) begin
        request_pixel($urandom_range(0, 2047), $urandom_range(0, 2047));
      end else begin
        request_pixel($urandom_range(0, dw - 1), $urandom_range(0, dh - 1));
      end
    end
  endtask

  // Result checker and receiver stall pattern.
  always @(posedge clk) begin : check_results
    scaled_pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual pixel_out %0d out_of_range %0d",
                 $time, pixel_out, out_of_range);
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_out !== want.pixel) begin
          mismatches++;
          $display("%0t: pixel_out expected %0d actual %0d", $time, want.pixel, pixel_out);
        end
        if (out_of_range !== want.flag) begin
          mismatches++;
          $display("%0t: out_of_range expected %0d actual %0d", $time, want.flag,
                   out_of_range);
        end
      end
    end
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (!no_idle && $urandom_range(0, 99) < 25) stall_left = stall_length();
    end
  end

  // Reset register values: interpolation, last row and column, outside requests.
  task automatic test_reset_defaults();
    send_store(0, 0, 8'hFF);
    send_store(1, 0, 8'h00);
    send_store(0, 1, 8'h00);
    send_store(1, 1, 8'hFF);
    request_pixel(0, 0);
    request_pixel(1, 1);
    request_pixel(511, 100);
    request_pixel(100, 511);
    request_pixel(511, 511);
    send_store(320, 5, 8'hA5);
    send_store(5, 240, 8'h5A);
    send_store(511, 511, 8'hFF);
    request_pixel(512, 0);
    request_pixel(0, 512);
    request_pixel(2047, 2047);
  endtask

  // A store beyond a narrowed source must not overwrite the stored pixel.
  task automatic test_store_outside_source();
    set_scaling(16, 16, 16, 16, ONE_Q, ONE_Q);
    send_store(10, 3, 8'h3C);
    set_scaling(8, 8, 16, 16, ONE_Q, ONE_Q);
    send_store(10, 3, 8'hC3);
    send_store(3, 10, 8'hC3);
    set_scaling(16, 16, 16, 16, ONE_Q, ONE_Q);
    request_pixel(10, 3);
  endtask

  // Saturated sizes, zero sizes, extreme ratios and unused register indexes.
  task automatic test_register_extremes();
    set_scaling(1, 1, 1, 1, 0, 0);
    send_store(1, 0, 8'h77);
    request_pixel(0, 0);
    request_pixel(1, 0);
    set_scaling(0, 1023, 4095, 0, RATIO_MAX, 0);
    request_pixel(2047, 0);
    set_scaling(1023, 0, 0, 4095, 0, RATIO_MAX);
    request_pixel(0, 2047);
    set_scaling(SRC_W_MAX, SRC_H_MAX, bir_pkg::MAX_DST_SIZE, bir_pkg::MAX_DST_SIZE,
                256, 256);
    send_store(511, 511, 8'hFF);
    request_pixel(2047, 2047);
    request_pixel(2043, 2043);
    wait_for_idle();
    cfg_write(REG_SPARE_6, 32'hFFFF_FFFF);
    cfg_write(REG_SPARE_7, 32'hFFFF_FFFF);
    request_pixel(2043, 2042);
    set_scaling(SRC_W_MAX, SRC_H_MAX, bir_pkg::MAX_DST_SIZE, bir_pkg::MAX_DST_SIZE,
                RATIO_MAX, RATIO_MAX);
    request_pixel(0, 0);
    request_pixel(1, 0);
  endtask

  task automatic test_random_settings();
    int sw;
    int sh;
    int dw;
    int dh;
    for (int phase = 0; phase < 10; phase++) begin
      sw = pick_src_size();
      sh = pick_src_size();
      dw = pick_dst_size();
      dh = pick_dst_size();
      set_scaling(sw, sh, dw, dh, ratio_for(sw, dw), ratio_for(sh, dh));
      random_traffic(35);
    end
  endtask

  // The receiver holds off while the sender keeps offering requests.
  task automatic test_output_backpressure();
    set_scaling(6, 6, 13, 13, ratio_for(6, 13), ratio_for(6, 13));
    no_idle      = 1'b1;
    hold_request = HOLD_CYCLES;
    random_traffic(25);
    no_idle = 1'b0;
  endtask

  // No gaps on either side.
  task automatic test_back_to_back();
    set_scaling(20, 12, 37, 29, ratio_for(20, 37), ratio_for(12, 29));
    no_idle = 1'b1;
    random_traffic(40);
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_store_outside_source();
    test_register_extremes();
    test_random_settings();
    test_output_backpressure();
    test_back_to_back();
    wait_for_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("[bilinear_image_resize] OK");
    end else begin
      $display("[bilinear_image_resize] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/bir_pkg.sv
rtl/bir_ram.sv
rtl/bilinear_image_resize.sv
test/bilinear_image_resize_test.sv
